FILE: hdl/prq_pkg.sv
package prq_pkg;

   localparam int OCC_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] time_left;
      logic [14:0] id;
   } entry_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   function automatic logic outranks(entry_type a, entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = a.prio > b.prio;
      end else if (a.time_left != b.time_left) begin
         result = a.time_left < b.time_left;
      end else begin
         result = a.id < b.id;
      end
      return result;
   endfunction

endpackage

FILE: hdl/prq_req_if.sv
interface prq_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  priority_req;
   logic [15:0] time_left;
   logic [14:0] proc_id;

   modport source (output valid, output opcode, output priority_req,
                   output time_left, output proc_id, input ready);
   modport sink (input valid, input opcode, input priority_req,
                 input time_left, input proc_id, output ready);
endinterface

FILE: hdl/prq_rsp_if.sv
interface prq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [14:0] head_id;
   logic [7:0]  head_priority;
   logic [15:0] head_time;
   logic [4:0]  occupancy;

   modport source (output valid, output status, output head_id, output head_priority,
                   output head_time, output occupancy, input ready);
   modport sink (input valid, input status, input head_id, input head_priority,
                 input head_time, input occupancy, output ready);
endinterface

FILE: hdl/prq_ctrl.sv
module prq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prq_pkg::cmd_type cmd
);

   prq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = prq_pkg::ST_EXEC;
            end
         end
         prq_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("executed operation produced no result");

   a_load_enters_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == prq_pkg::ST_EXEC && !req_ready))
      else $error("accepted request not held for execution");

   a_no_load_and_exec: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.exec))
      else $error("load and execute in the same cycle");

endmodule

FILE: hdl/prq_datapath.sv
module prq_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  prq_pkg::cmd_type cmd,
   input  logic             opcode,
   input  logic [7:0]       priority_req,
   input  logic [15:0]      time_left,
   input  logic [14:0]      proc_id,
   output logic [1:0]       status,
   output logic [14:0]      head_id,
   output logic [7:0]       head_priority,
   output logic [15:0]      head_time,
   output logic [4:0]       occupancy
);

   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W = prq_pkg::OCC_W;

   prq_pkg::entry_type slot_ff [QUEUE_DEPTH];
   prq_pkg::entry_type slot_in [QUEUE_DEPTH];
   prq_pkg::entry_type prev_slot [QUEUE_DEPTH];
   prq_pkg::entry_type next_slot [QUEUE_DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic               op_ff;
   prq_pkg::entry_type new_ff;
   logic [1:0]         status_ff, status_in;
   prq_pkg::entry_type head_ff, head_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W+CW-1:0] occ_wide;

   logic [QUEUE_DEPTH-1:0] ins_vec;
   logic [QUEUE_DEPTH-1:0] ins_prev;
   logic full, empty, do_insert, do_pop;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_insert = cmd.exec && op_ff == prq_pkg::OP_INSERT && !full;
   assign do_pop    = cmd.exec && op_ff == prq_pkg::OP_POP && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      assign ins_vec[i] = (CW'(i) < count_ff && prq_pkg::outranks(new_ff, slot_ff[i]))
                          || CW'(i) == count_ff;
      if (i == 0) begin : g_first
         assign ins_prev[i]  = 1'b0;
         assign prev_slot[i] = new_ff;
      end else begin : g_rest
         assign ins_prev[i]  = ins_vec[i-1];
         assign prev_slot[i] = slot_ff[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_slot[i] = slot_ff[i];
      end else begin : g_inner
         assign next_slot[i] = slot_ff[i+1];
      end
      assign slot_in[i] = do_insert ? (ins_prev[i] ? prev_slot[i] :
                                       ins_vec[i] ? new_ff : slot_ff[i]) :
                          do_pop ? next_slot[i] : slot_ff[i];
   end

   always_comb begin
      count_in  = count_ff;
      status_in = prq_pkg::STATUS_OK;
      head_in   = '0;
      if (op_ff == prq_pkg::OP_INSERT) begin
         if (full) begin
            status_in = prq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            status_in = prq_pkg::STATUS_EMPTY;
         end else begin
            count_in = count_ff - CW'(1);
            head_in  = slot_ff[0];
         end
      end
      occ_wide = {{OCC_W{1'b0}}, count_in};
      occ_in   = occ_wide[OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.load) begin
         op_ff            <= opcode;
         new_ff.prio      <= priority_req;
         new_ff.time_left <= time_left;
         new_ff.id        <= proc_id;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         head_ff   <= head_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign status        = status_ff;
   assign head_id       = head_ff.id;
   assign head_priority = head_ff.prio;
   assign head_time     = head_ff.time_left;
   assign occupancy     = occ_ff;

endmodule

FILE: hdl/priority_ready_queue_core.sv
// Sorted ready queue of process entries, head first.
// req_ch carries one operation per transfer: opcode 0 inserts the entry
// (priority_req, time_left, proc_id), opcode 1 pops the head entry.
// rsp_ch returns exactly one result per operation, in order: status
// (0 ok, 1 full on insert, 2 empty on pop), the popped entry (zero unless
// a pop succeeded) and the occupancy after the operation.
// Ordering: higher priority first, then smaller remaining time, then
// smaller process id; an insert goes ahead of the first entry it beats.
// Each request transferred on req_ch is loaded into the operand registers
// and then executed in the controller's execute step, which updates the
// compare-and-shift slot array and registers the result for rsp_ch. The
// controller takes no new request until the loaded one has executed.
// When rsp_ch stalls, the result holds in the output register; one more
// request is still taken and waits in the execute step until the output
// register is free. Reset empties the queue and drops any pending result;
// slot contents are not cleared.
module priority_ready_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   prq_req_if.sink     req_ch,
   prq_rsp_if.source   rsp_ch
);

   prq_pkg::cmd_type cmd;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   prq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .opcode         (req_ch.opcode),
      .priority_req   (req_ch.priority_req),
      .time_left      (req_ch.time_left),
      .proc_id        (req_ch.proc_id),
      .status         (rsp_ch.status),
      .head_id        (rsp_ch.head_id),
      .head_priority  (rsp_ch.head_priority),
      .head_time      (rsp_ch.head_time),
      .occupancy      (rsp_ch.occupancy)
   );

endmodule
